// ===== design/mpct_pkg.sv =====
// Shared types and constants for the mouse packet cursor tracker.
package mpct_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_W = 13;
	localparam int DELTA_W = 10;

	localparam logic [7:0] ACK_BYTE = 8'hFA;
	localparam logic [7:0] HDR_MASK = 8'hC8;
	localparam logic [7:0] HDR_MATCH = 8'h08;

	localparam int HDR_LEFT_BIT = 0;
	localparam int HDR_RIGHT_BIT = 1;
	localparam int HDR_MIDDLE_BIT = 2;
	localparam int HDR_X_SIGN_BIT = 4;
	localparam int HDR_Y_SIGN_BIT = 5;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST = 13'd1024;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

	typedef enum logic [0:0] {
		REG_SCREEN_WIDTH = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] header;
		logic [7:0] x_delta;
		logic [7:0] y_delta;
	} pkt_t;

endpackage

// ===== design/mpct_framer.sv =====
// Byte framer: drops the acknowledge byte and assembles three-byte packets.
module mpct_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	output logic              pkt_valid,
	output mpct_pkg::pkt_t    pkt
);
	import mpct_pkg::*;

	typedef enum logic [2:0] {
		POS_HDR = 3'b001,
		POS_X   = 3'b010,
		POS_Y   = 3'b100
	} pos_t;

	pos_t       pos_q;
	logic       awaiting_ack_q;
	logic [7:0] header_q;
	logic [7:0] x_delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HDR;
			awaiting_ack_q <= 1'b1;
			header_q <= 8'h00;
			x_delta_q <= 8'h00;
		end else if (accept) begin
			case (pos_q)
				POS_X: begin
					x_delta_q <= rx_byte;
					pos_q <= POS_Y;
				end
				POS_Y: begin
					pos_q <= POS_HDR;
				end
				default: begin
					pos_q <= POS_HDR;
					if (awaiting_ack_q && (rx_byte == ACK_BYTE)) begin
						awaiting_ack_q <= 1'b0;
					end else if ((rx_byte & HDR_MASK) == HDR_MATCH) begin
						header_q <= rx_byte;
						pos_q <= POS_X;
					end
				end
			endcase
		end
	end

	// the Y byte completes a packet
	assign pkt_valid = accept && (pos_q == POS_Y);
	assign pkt.header = header_q;
	assign pkt.x_delta = x_delta_q;
	assign pkt.y_delta = rx_byte;

endmodule

// ===== design/mpct_axis.sv =====
// One cursor axis: add a signed step, clamp to [0, limit], report the real move.
module mpct_axis #(
	parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0]              pos,
	input  logic signed [mpct_pkg::DELTA_W-1:0] delta,
	input  logic [COORD_BITS-1:0]              limit,
	output logic [COORD_BITS-1:0]              next,
	output logic [COORD_BITS:0]                moved
);
	import mpct_pkg::*;

	localparam int SW = ((COORD_BITS > DELTA_W) ? COORD_BITS : DELTA_W) + 2;

	logic signed [SW-1:0] pos_ext;
	logic signed [SW-1:0] delta_ext;
	logic signed [SW-1:0] lim_ext;
	logic signed [SW-1:0] sum;

	always_comb begin
		pos_ext = signed'(SW'(pos));
		delta_ext = SW'(delta);
		lim_ext = signed'(SW'(limit));
		sum = pos_ext + delta_ext;
		if (sum < 0) begin
			next = '0;
		end else if (sum > lim_ext) begin
			next = limit;
		end else begin
			next = sum[COORD_BITS-1:0];
		end
		moved = (COORD_BITS+1)'(next) - (COORD_BITS+1)'(pos);
	end

endmodule

// ===== design/mouse_packet_cursor_tracker_top.sv =====
// Top level of the mouse packet cursor tracker: framing, cursor update, output register.
// Throughput: one mouse byte accepted per cycle, sustained, with no bubbles while the
//   receiver keeps taking results; input stalls only when a packet waits behind a held result.
// Result path: accepting a packet's last byte fills the packet register; the result register
//   (where the clamp lands) loads from it once free and raises out_valid.
// Reset (arst_n low, asynchronous): wait for the acknowledge byte, expect a header,
//   cursor at (0,0), screen 1024 x 768, no item in flight.
module mouse_packet_cursor_tracker_top #(
	parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [mpct_pkg::CFG_W-1:0]     cfg_wdata,
	// mouse byte channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [COORD_BITS-1:0]          cursor_x,
	output logic [COORD_BITS-1:0]          cursor_y,
	output logic                           left_button,
	output logic                           middle_button,
	output logic                           right_button,
	output logic signed [COORD_BITS:0]     moved_x,
	output logic signed [COORD_BITS:0]     moved_y
);
	import mpct_pkg::*;

	// width that holds both a configured size and the coordinate ceiling
	localparam int LW = (CFG_W > COORD_BITS) ? CFG_W : COORD_BITS;
	localparam logic [LW-1:0] COORD_MAX = LW'({COORD_BITS{1'b1}});

	// ---------------------------------------------------------------
	// Configuration registers: the user must write them only while the block is idle; not enforced.
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] screen_width_q;
	logic [CFG_W-1:0] screen_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SCREEN_WIDTH:  screen_width_q <= cfg_wdata;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Axis bounds: size minus one, a zero size acting as one, capped at the
	// largest coordinate.
	logic [LW-1:0]         bound_w;
	logic [LW-1:0]         bound_h;
	logic [COORD_BITS-1:0] limit_x;
	logic [COORD_BITS-1:0] limit_y;

	always_comb begin
		bound_w = (screen_width_q == '0) ? '0 : LW'(screen_width_q - 1'b1);
		bound_h = (screen_height_q == '0) ? '0 : LW'(screen_height_q - 1'b1);
		limit_x = (bound_w > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
		                                : bound_w[COORD_BITS-1:0];
		limit_y = (bound_h > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
		                                : bound_h[COORD_BITS-1:0];
	end

	// ---------------------------------------------------------------
	// Flow control. The result register and the packet register each
	// hold one item; the packet register refills the same cycle that it
	// drains, so bytes keep flowing unless a packet waits behind a held result.
	// ---------------------------------------------------------------
	logic pkt_valid_s1;
	logic out_load;
	logic s1_free;
	logic accept;

	assign out_load = pkt_valid_s1 && (!out_valid || !out_stall);
	assign s1_free  = !pkt_valid_s1 || out_load;
	assign in_stall = !s1_free;
	assign accept   = in_valid && !in_stall;

	// ---------------------------------------------------------------
	// Framing: acknowledge drop, header check, byte position.
	// ---------------------------------------------------------------
	logic pkt_done;
	pkt_t pkt;

	mpct_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.pkt_valid (pkt_done),
		.pkt       (pkt)
	);

	// Packet register: hold a complete packet until the result register takes it.
	pkt_t pkt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_s1 <= 1'b0;
		end else if (accept && pkt_done) begin
			pkt_valid_s1 <= 1'b1;
		end else if (out_load) begin
			pkt_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pkt_done) begin
			pkt_s1 <= pkt;
		end
	end

	// ---------------------------------------------------------------
	// Cursor update: sign extend with the header's sign bits, invert Y
	// since mouse Y points up, then clamp each axis.
	// ---------------------------------------------------------------
	logic [COORD_BITS-1:0]        pointer_x_q;
	logic [COORD_BITS-1:0]        pointer_y_q;
	logic signed [DELTA_W-1:0]    step_x;
	logic signed [DELTA_W-1:0]    dy;
	logic signed [DELTA_W-1:0]    step_y;
	logic [COORD_BITS-1:0]        next_x;
	logic [COORD_BITS-1:0]        next_y;
	logic [COORD_BITS:0]          mv_x;
	logic [COORD_BITS:0]          mv_y;

	always_comb begin
		step_x = signed'({{(DELTA_W-8){pkt_s1.header[HDR_X_SIGN_BIT]}}, pkt_s1.x_delta});
		dy     = signed'({{(DELTA_W-8){pkt_s1.header[HDR_Y_SIGN_BIT]}}, pkt_s1.y_delta});
		step_y = -dy;
	end

	mpct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.pos   (pointer_x_q),
		.delta (step_x),
		.limit (limit_x),
		.next  (next_x),
		.moved (mv_x)
	);

	mpct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.pos   (pointer_y_q),
		.delta (step_y),
		.limit (limit_y),
		.next  (next_y),
		.moved (mv_y)
	);

	// Cursor position advances as each packet moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_x_q <= '0;
			pointer_y_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) begin
				pointer_x_q <= next_x;
				pointer_y_q <= next_y;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result payload: hold while stalled, load with the packet.
	always_ff @(posedge clk) begin
		if (out_load) begin
			cursor_x <= next_x;
			cursor_y <= next_y;
			left_button <= pkt_s1.header[HDR_LEFT_BIT];
			middle_button <= pkt_s1.header[HDR_MIDDLE_BIT];
			right_button <= pkt_s1.header[HDR_RIGHT_BIT];
			moved_x <= signed'(mv_x);
			moved_y <= signed'(mv_y);
		end
	end

endmodule
